// ===== rtl/core/gbcs_pkg.sv =====
// Package for the grid best-corner selector: field widths, reset values,
// operation, status and register codes, controller states and the cell entry.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps

package gbcs_pkg;

  localparam int COORD_W    = 12;
  localparam int CS_W       = 9;
  localparam int GW_W       = 11;
  localparam int MARGIN_W   = 7;
  localparam int SCORE_W    = 32;
  localparam int LVL_W      = 3;
  localparam int OP_W       = 3;
  localparam int STS_W      = 3;
  localparam int RD_W       = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MAX_CELLS  = 1024;

  localparam logic [CS_W-1:0]    CELL_SIZE_RST    = CS_W'(32);
  localparam logic [GW_W-1:0]    GRID_WIDTH_RST   = GW_W'(20);
  localparam logic [MARGIN_W-1:0] EDGE_MARGIN_RST = MARGIN_W'(5);
  localparam logic [COORD_W-1:0] IMAGE_WIDTH_RST  = COORD_W'(640);
  localparam logic [COORD_W-1:0] IMAGE_HEIGHT_RST = COORD_W'(480);
  localparam logic [SCORE_W-1:0] MIN_SCORE_RST    = '0;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_LOCK   = 3'd1,
    OP_UNLOCK = 3'd2,
    OP_OFFER  = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [STS_W-1:0] {
    STS_DONE       = 3'd0,
    STS_STORED     = 3'd1,
    STS_MARGIN     = 3'd2,
    STS_LOCKED     = 3'd3,
    STS_NOT_BETTER = 3'd4,
    STS_RANGE      = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_SIZE    = 3'd0,
    REG_GRID_WIDTH   = 3'd1,
    REG_EDGE_MARGIN  = 3'd2,
    REG_IMAGE_WIDTH  = 3'd3,
    REG_IMAGE_HEIGHT = 3'd4,
    REG_MIN_SCORE    = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_DIV,
    S_MUL,
    S_ADDR,
    S_READ,
    S_EVAL,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LVL_W-1:0]   level;
    logic [SCORE_W-1:0] score;
    logic               locked;
  } cell_entry_t;

endpackage

// ===== rtl/core/gbcs_div.sv =====
// Restoring divider for one coordinate by the cell size, one quotient bit per cycle.
// Depends on gbcs_pkg for the coordinate and cell size widths.
`timescale 1ns / 1ps

module gbcs_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [gbcs_pkg::COORD_W-1:0] dividend_i,
  input  logic [gbcs_pkg::CS_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [gbcs_pkg::COORD_W-1:0] quotient_o
);

  localparam int CntW = $clog2(gbcs_pkg::COORD_W + 1);
  localparam int RemW = gbcs_pkg::CS_W - 1;

  logic [RemW-1:0]                rem_q;
  logic [gbcs_pkg::COORD_W-1:0]   quo_q;
  logic [gbcs_pkg::CS_W-1:0]      dsr_q;
  logic [CntW-1:0]                cnt_q;
  logic                           busy_q;
  logic                           done_q;
  logic [gbcs_pkg::CS_W-1:0]      rem_sh;
  logic [gbcs_pkg::CS_W-1:0]      rem_nx;
  logic                           ge;

  assign rem_sh = {rem_q, quo_q[gbcs_pkg::COORD_W-1]};
  assign ge     = (rem_sh >= dsr_q);
  assign rem_nx = ge ? (rem_sh - dsr_q) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(gbcs_pkg::COORD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_nx[RemW-1:0];
      quo_q <= {quo_q[gbcs_pkg::COORD_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/core/gbcs_mem.sv =====
// Cell store: one write port and one read port with registered read data.
// Depends on gbcs_pkg for the cell entry type.
`timescale 1ns / 1ps

module gbcs_mem #(
  parameter int Depth = gbcs_pkg::MAX_CELLS,
  parameter int AddrW = 10
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  gbcs_pkg::cell_entry_t wdata_i,
  input  logic                  re_i,
  input  logic [AddrW-1:0]      raddr_i,
  output gbcs_pkg::cell_entry_t rdata_o
);

  gbcs_pkg::cell_entry_t mem_q [Depth];
  gbcs_pkg::cell_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/grid_best_corner_selector_unit.sv =====
// Top level of the grid best-corner selector: controller, configuration registers,
// cell number arithmetic and result register. Depends on gbcs_pkg, gbcs_div, gbcs_mem.
//
//   Channel | Direction | Signals
//   in      | input     | in_valid_i, in_ready_o, operation_i .. cell_index_i
//   out     | output    | out_valid_o, out_ready_i, status_o .. out_level_o
//   cfg     | input     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
//
// One transaction is worked on at a time. A read in range passes the read, evaluation
// and response states to the output register; a lock, unlock or offer that reaches the
// store passes the 12 steps of the two bit-serial dividers, the multiply and address
// states and the store read-modify-write. A clear sweeps the store one cell per cycle
// and then reaches the output register; the next transaction is taken in the cycle after
// a result is loaded. After reset the same sweep runs over every cell before the first
// transaction is accepted; configuration writes are taken at any time.
// A result waiting in the output register holds back only the next completion.
`timescale 1ns / 1ps

module grid_best_corner_selector_unit #(
  parameter int MaxCells = gbcs_pkg::MAX_CELLS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [gbcs_pkg::OP_W-1:0]       operation_i,
  input  logic [gbcs_pkg::COORD_W-1:0]    coord_x_i,
  input  logic [gbcs_pkg::COORD_W-1:0]    coord_y_i,
  input  logic [gbcs_pkg::LVL_W-1:0]      pyramid_level_i,
  input  logic [gbcs_pkg::SCORE_W-1:0]    corner_score_i,
  input  logic [gbcs_pkg::RD_W-1:0]       cell_index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [gbcs_pkg::STS_W-1:0]      status_o,
  output logic                            found_o,
  output logic [gbcs_pkg::COORD_W-1:0]    out_x_o,
  output logic [gbcs_pkg::COORD_W-1:0]    out_y_o,
  output logic [gbcs_pkg::LVL_W-1:0]      out_level_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gbcs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gbcs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AddrW = (MaxCells > 1) ? $clog2(MaxCells) : 1;
  localparam int ProdW = gbcs_pkg::COORD_W + gbcs_pkg::GW_W;
  localparam int IdxW  = ProdW + 1;
  localparam logic [IdxW-1:0]  MaxIdx   = IdxW'(MaxCells);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MaxCells - 1);

  gbcs_pkg::state_e state_q, state_d;
  logic [AddrW-1:0] cnt_q, cnt_d;

  logic [gbcs_pkg::CS_W-1:0]     cell_size_q;
  logic [gbcs_pkg::GW_W-1:0]     grid_width_q;
  logic [gbcs_pkg::MARGIN_W-1:0] edge_margin_q;
  logic [gbcs_pkg::COORD_W-1:0]  image_width_q;
  logic [gbcs_pkg::COORD_W-1:0]  image_height_q;
  logic [gbcs_pkg::SCORE_W-1:0]  min_score_q;

  gbcs_pkg::op_e                op_q;
  logic [gbcs_pkg::COORD_W-1:0] x_q;
  logic [gbcs_pkg::COORD_W-1:0] y_q;
  logic [gbcs_pkg::LVL_W-1:0]   lvl_q;
  logic [gbcs_pkg::SCORE_W-1:0] score_q;
  logic [AddrW-1:0]             addr_q;
  logic [ProdW-1:0]             prod_q;

  gbcs_pkg::status_e            res_status_q, res_status_d;
  logic                         res_found_q, res_found_d;
  logic [gbcs_pkg::COORD_W-1:0] res_x_q, res_x_d;
  logic [gbcs_pkg::COORD_W-1:0] res_y_q, res_y_d;
  logic [gbcs_pkg::LVL_W-1:0]   res_lvl_q, res_lvl_d;
  logic                         res_load;

  logic                         out_valid_q, out_valid_d;
  gbcs_pkg::status_e            out_status_q;
  logic                         out_found_q;
  logic [gbcs_pkg::COORD_W-1:0] out_x_q;
  logic [gbcs_pkg::COORD_W-1:0] out_y_q;
  logic [gbcs_pkg::LVL_W-1:0]   out_lvl_q;
  logic                         out_load;

  gbcs_pkg::op_e                op_in;
  logic                         in_fire;
  logic [gbcs_pkg::COORD_W-1:0] lvl_w;
  logic [gbcs_pkg::COORD_W-1:0] lvl_h;
  logic [gbcs_pkg::COORD_W:0]   x_plus_m;
  logic [gbcs_pkg::COORD_W:0]   y_plus_m;
  logic [gbcs_pkg::COORD_W-1:0] margin_ext;
  logic                         margin_fail;
  logic [gbcs_pkg::COORD_W-1:0] div_x_in;
  logic [gbcs_pkg::COORD_W-1:0] div_y_in;
  logic [gbcs_pkg::CS_W-1:0]    divisor;
  logic                         rd_ok;
  logic                         div_start;
  logic                         div_x_done;
  logic                         div_y_done;
  logic [gbcs_pkg::COORD_W-1:0] col;
  logic [gbcs_pkg::COORD_W-1:0] row;
  logic [IdxW-1:0]              idx;

  logic                         mem_we;
  logic [AddrW-1:0]             mem_waddr;
  gbcs_pkg::cell_entry_t        mem_wdata;
  logic                         mem_re;
  gbcs_pkg::cell_entry_t        mem_rdata;

  assign in_ready_o  = (state_q == gbcs_pkg::S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign op_in       = gbcs_pkg::op_e'(operation_i);

  assign lvl_w       = image_width_q >> pyramid_level_i;
  assign lvl_h       = image_height_q >> pyramid_level_i;
  assign margin_ext  = gbcs_pkg::COORD_W'(edge_margin_q);
  assign x_plus_m    = {1'b0, coord_x_i} + {1'b0, margin_ext};
  assign y_plus_m    = {1'b0, coord_y_i} + {1'b0, margin_ext};
  assign margin_fail = (coord_x_i < margin_ext) || (coord_y_i < margin_ext) ||
                       (x_plus_m >= {1'b0, lvl_w}) || (y_plus_m >= {1'b0, lvl_h});

  assign div_x_in = (op_in == gbcs_pkg::OP_OFFER) ? (coord_x_i << pyramid_level_i) : coord_x_i;
  assign div_y_in = (op_in == gbcs_pkg::OP_OFFER) ? (coord_y_i << pyramid_level_i) : coord_y_i;
  assign divisor  = (cell_size_q == '0) ? gbcs_pkg::CS_W'(1) : cell_size_q;
  assign rd_ok    = (IdxW'(cell_index_i) < MaxIdx);
  assign idx      = {1'b0, prod_q} + IdxW'(col);

  gbcs_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_x_in),
    .divisor_i  (divisor),
    .done_o     (div_x_done),
    .quotient_o (col)
  );

  gbcs_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_y_in),
    .divisor_i  (divisor),
    .done_o     (div_y_done),
    .quotient_o (row)
  );

  gbcs_mem #(
    .Depth (MaxCells),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (addr_q),
    .rdata_o (mem_rdata)
  );

  // Outside the clear sweeps the store is written only in the evaluation state, after
  // its read, and the next transaction is accepted later, so a read never overlaps a
  // write to the same cell.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = cnt_q;
    mem_wdata    = '{x: '0, y: '0, level: '0, locked: 1'b0,
                     score: (state_q == gbcs_pkg::S_INIT) ? gbcs_pkg::MIN_SCORE_RST
                                                          : min_score_q};
    res_load     = 1'b0;
    res_status_d = gbcs_pkg::STS_DONE;
    res_found_d  = 1'b0;
    res_x_d      = '0;
    res_y_d      = '0;
    res_lvl_d    = '0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      gbcs_pkg::S_INIT: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + AddrW'(1);
        if (cnt_q == LastAddr) begin
          cnt_d   = '0;
          state_d = gbcs_pkg::S_IDLE;
        end
      end
      gbcs_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (op_in) inside
            gbcs_pkg::OP_CLEAR: begin
              cnt_d   = '0;
              state_d = gbcs_pkg::S_CLEAR;
            end
            gbcs_pkg::OP_LOCK, gbcs_pkg::OP_UNLOCK: begin
              div_start = 1'b1;
              state_d   = gbcs_pkg::S_DIV;
            end
            gbcs_pkg::OP_OFFER: begin
              if (margin_fail) begin
                res_load     = 1'b1;
                res_status_d = gbcs_pkg::STS_MARGIN;
                state_d      = gbcs_pkg::S_RESP;
              end else begin
                div_start = 1'b1;
                state_d   = gbcs_pkg::S_DIV;
              end
            end
            gbcs_pkg::OP_READ: begin
              if (rd_ok) begin
                state_d = gbcs_pkg::S_READ;
              end else begin
                res_load     = 1'b1;
                res_status_d = gbcs_pkg::STS_RANGE;
                state_d      = gbcs_pkg::S_RESP;
              end
            end
            default: begin
              res_load = 1'b1;
              state_d  = gbcs_pkg::S_RESP;
            end
          endcase
        end
      end
      gbcs_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + AddrW'(1);
        if (cnt_q == LastAddr) begin
          cnt_d    = '0;
          res_load = 1'b1;
          state_d  = gbcs_pkg::S_RESP;
        end
      end
      gbcs_pkg::S_DIV: begin
        if (div_x_done && div_y_done) begin
          state_d = gbcs_pkg::S_MUL;
        end
      end
      gbcs_pkg::S_MUL: begin
        if (col >= gbcs_pkg::COORD_W'(grid_width_q)) begin
          res_load     = 1'b1;
          res_status_d = gbcs_pkg::STS_RANGE;
          state_d      = gbcs_pkg::S_RESP;
        end else begin
          state_d = gbcs_pkg::S_ADDR;
        end
      end
      gbcs_pkg::S_ADDR: begin
        if (idx < MaxIdx) begin
          state_d = gbcs_pkg::S_READ;
        end else begin
          res_load     = 1'b1;
          res_status_d = gbcs_pkg::STS_RANGE;
          state_d      = gbcs_pkg::S_RESP;
        end
      end
      gbcs_pkg::S_READ: begin
        mem_re  = 1'b1;
        state_d = gbcs_pkg::S_EVAL;
      end
      gbcs_pkg::S_EVAL: begin
        res_load  = 1'b1;
        mem_waddr = addr_q;
        state_d   = gbcs_pkg::S_RESP;
        case (op_q) inside
          gbcs_pkg::OP_LOCK, gbcs_pkg::OP_UNLOCK: begin
            mem_we           = 1'b1;
            mem_wdata        = mem_rdata;
            mem_wdata.locked = (op_q == gbcs_pkg::OP_LOCK);
          end
          gbcs_pkg::OP_OFFER: begin
            if (mem_rdata.locked) begin
              res_status_d = gbcs_pkg::STS_LOCKED;
            end else if (!(score_q > mem_rdata.score)) begin
              res_status_d = gbcs_pkg::STS_NOT_BETTER;
            end else begin
              mem_we       = 1'b1;
              mem_wdata    = '{x: x_q, y: y_q, level: lvl_q, score: score_q, locked: 1'b0};
              res_status_d = gbcs_pkg::STS_STORED;
            end
          end
          gbcs_pkg::OP_READ: begin
            res_found_d = (mem_rdata.score > min_score_q);
            res_x_d     = mem_rdata.x;
            res_y_d     = mem_rdata.y;
            res_lvl_d   = mem_rdata.level;
          end
          default: begin
            res_status_d = gbcs_pkg::STS_DONE;
          end
        endcase
      end
      gbcs_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = gbcs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = gbcs_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbcs_pkg::S_INIT;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q    <= gbcs_pkg::CELL_SIZE_RST;
      grid_width_q   <= gbcs_pkg::GRID_WIDTH_RST;
      edge_margin_q  <= gbcs_pkg::EDGE_MARGIN_RST;
      image_width_q  <= gbcs_pkg::IMAGE_WIDTH_RST;
      image_height_q <= gbcs_pkg::IMAGE_HEIGHT_RST;
      min_score_q    <= gbcs_pkg::MIN_SCORE_RST;
    end else if (cfg_valid_i) begin
      unique case (gbcs_pkg::cfg_reg_e'(cfg_index_i))
        gbcs_pkg::REG_CELL_SIZE:    cell_size_q    <= cfg_data_i[gbcs_pkg::CS_W-1:0];
        gbcs_pkg::REG_GRID_WIDTH:   grid_width_q   <= cfg_data_i[gbcs_pkg::GW_W-1:0];
        gbcs_pkg::REG_EDGE_MARGIN:  edge_margin_q  <= cfg_data_i[gbcs_pkg::MARGIN_W-1:0];
        gbcs_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[gbcs_pkg::COORD_W-1:0];
        gbcs_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[gbcs_pkg::COORD_W-1:0];
        gbcs_pkg::REG_MIN_SCORE:    min_score_q    <= cfg_data_i[gbcs_pkg::SCORE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= op_in;
      x_q     <= div_x_in;
      y_q     <= div_y_in;
      lvl_q   <= pyramid_level_i;
      score_q <= corner_score_i;
      addr_q  <= AddrW'(cell_index_i);
    end else if (state_q == gbcs_pkg::S_ADDR) begin
      addr_q <= idx[AddrW-1:0];
    end
    if (state_q == gbcs_pkg::S_MUL) begin
      prod_q <= ProdW'(row) * ProdW'(grid_width_q);
    end
    if (res_load) begin
      res_status_q <= res_status_d;
      res_found_q  <= res_found_d;
      res_x_q      <= res_x_d;
      res_y_q      <= res_y_d;
      res_lvl_q    <= res_lvl_d;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_x_q      <= res_x_q;
      out_y_q      <= res_y_q;
      out_lvl_q    <= res_lvl_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign found_o     = out_found_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_level_o = out_lvl_q;

endmodule

// ===== rtl/core/gbcs_checker.sv =====
// Port-level checks for the grid best-corner selector and the bind that attaches them.
// Depends on gbcs_pkg and on the top level grid_best_corner_selector_unit.
`timescale 1ns / 1ps

module gbcs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [gbcs_pkg::STS_W-1:0]   status_o,
  input logic                         found_o,
  input logic [gbcs_pkg::COORD_W-1:0] out_x_o,
  input logic [gbcs_pkg::COORD_W-1:0] out_y_o,
  input logic [gbcs_pkg::LVL_W-1:0]   out_level_o
);

  // A stalled result keeps its valid and its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(found_o) &&
      $stable(out_x_o) && $stable(out_y_o) && $stable(out_level_o))
    else $error("stalled result changed");

  // Only one transaction is in flight: ready drops right after an acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("transaction accepted while another is in flight");

  // Only a result with the done status, as a read gives, can report a corner.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == 3'(gbcs_pkg::STS_DONE))
    else $error("found set on a result that is not a read");

  // Results other than done carry no cell contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != 3'(gbcs_pkg::STS_DONE) |->
      !found_o && out_x_o == '0 && out_y_o == '0 && out_level_o == '0)
    else $error("cell contents on a non-read result");

endmodule

bind grid_best_corner_selector_unit gbcs_checker u_gbcs_checker (.*);

// ===== bench/grid_best_corner_selector_unit_tb.sv =====
// Self-checking testbench for grid_best_corner_selector_unit: directed and random
// grid operations with a built-in predictor of the per-cell best corner store.
// Depends on gbcs_pkg and the grid_best_corner_selector_unit RTL.
`timescale 1ns / 1ps

module grid_best_corner_selector_unit_tb;

  typedef struct packed {
    gbcs_pkg::status_e            status;
    logic                         found;
    logic [gbcs_pkg::COORD_W-1:0] x;
    logic [gbcs_pkg::COORD_W-1:0] y;
    logic [gbcs_pkg::LVL_W-1:0]   level;
  } sel_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_valid = 1'b0;
  logic [gbcs_pkg::OP_W-1:0]       operation = '0;
  logic [gbcs_pkg::COORD_W-1:0]    coord_x = '0;
  logic [gbcs_pkg::COORD_W-1:0]    coord_y = '0;
  logic [gbcs_pkg::LVL_W-1:0]      pyramid_level = '0;
  logic [gbcs_pkg::SCORE_W-1:0]    corner_score = '0;
  logic [gbcs_pkg::RD_W-1:0]       cell_index = '0;
  logic                            out_ready = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic [gbcs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [gbcs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic                         in_ready;
  logic                         out_valid;
  logic [gbcs_pkg::STS_W-1:0]   status;
  logic                         found;
  logic [gbcs_pkg::COORD_W-1:0] out_x;
  logic [gbcs_pkg::COORD_W-1:0] out_y;
  logic [gbcs_pkg::LVL_W-1:0]   out_level;
  logic                         cfg_ready;

  logic [gbcs_pkg::CS_W-1:0]     sel_cell_size;
  logic [gbcs_pkg::GW_W-1:0]     sel_grid_width;
  logic [gbcs_pkg::MARGIN_W-1:0] sel_edge_margin;
  logic [gbcs_pkg::COORD_W-1:0]  sel_image_width;
  logic [gbcs_pkg::COORD_W-1:0]  sel_image_height;
  logic [gbcs_pkg::SCORE_W-1:0]  sel_min_score;

  logic [gbcs_pkg::COORD_W-1:0] grid_x     [gbcs_pkg::MAX_CELLS];
  logic [gbcs_pkg::COORD_W-1:0] grid_y     [gbcs_pkg::MAX_CELLS];
  logic [gbcs_pkg::LVL_W-1:0]   grid_lvl   [gbcs_pkg::MAX_CELLS];
  logic [gbcs_pkg::SCORE_W-1:0] grid_score [gbcs_pkg::MAX_CELLS];
  logic                         grid_lock  [gbcs_pkg::MAX_CELLS];

  sel_result_t pending_results[$];
  int unsigned mismatch_count = 0;
  bit          no_idle = 1'b0;

  int unsigned recent_x, recent_y, recent_cell;
  logic [gbcs_pkg::COORD_W-1:0] last_x, last_y;
  logic [gbcs_pkg::LVL_W-1:0]   last_lvl;
  logic [gbcs_pkg::SCORE_W-1:0] last_score;

  grid_best_corner_selector_unit u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (operation),
    .coord_x_i      (coord_x),
    .coord_y_i      (coord_y),
    .pyramid_level_i(pyramid_level),
    .corner_score_i (corner_score),
    .cell_index_i   (cell_index),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .found_o        (found),
    .out_x_o        (out_x),
    .out_y_o        (out_y),
    .out_level_o    (out_level),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("grid_best_corner_selector_unit: mismatch");
    $finish;
  end

  function automatic bit map_to_cell(input int unsigned px, input int unsigned py,
                                     output int unsigned cell_no);
    int unsigned cs, col, row;
    longint unsigned idx;
    cs = (sel_cell_size == 0) ? 1 : sel_cell_size;
    col = px / cs;
    row = py / cs;
    cell_no = 0;
    if (col >= sel_grid_width) return 1'b0;
    idx = 64'(row) * sel_grid_width + col;
    if (idx >= gbcs_pkg::MAX_CELLS) return 1'b0;
    cell_no = int'(idx);
    return 1'b1;
  endfunction

  function automatic void wipe_grid();
    for (int i = 0; i < gbcs_pkg::MAX_CELLS; i++) begin
      grid_x[i] = '0;
      grid_y[i] = '0;
      grid_lvl[i] = '0;
      grid_score[i] = sel_min_score;
      grid_lock[i] = 1'b0;
    end
  endfunction

  function automatic sel_result_t predict_item(input logic [gbcs_pkg::OP_W-1:0] op,
      input logic [gbcs_pkg::COORD_W-1:0] x, input logic [gbcs_pkg::COORD_W-1:0] y,
      input logic [gbcs_pkg::LVL_W-1:0] lvl, input logic [gbcs_pkg::SCORE_W-1:0] score,
      input logic [gbcs_pkg::RD_W-1:0] idx);
    sel_result_t res;
    int unsigned lw, lh, m, xi, yi, sx, sy, cell_no;
    res = '0;
    res.status = gbcs_pkg::STS_DONE;
    xi = x;
    yi = y;
    m = sel_edge_margin;
    case (op) inside
      gbcs_pkg::OP_CLEAR: wipe_grid();
      gbcs_pkg::OP_LOCK, gbcs_pkg::OP_UNLOCK: begin
        if (map_to_cell(xi, yi, cell_no)) grid_lock[cell_no] = (op == gbcs_pkg::OP_LOCK);
        else res.status = gbcs_pkg::STS_RANGE;
      end
      gbcs_pkg::OP_OFFER: begin
        lw = sel_image_width >> lvl;
        lh = sel_image_height >> lvl;
        if (xi < m || yi < m || xi + m >= lw || yi + m >= lh) begin
          res.status = gbcs_pkg::STS_MARGIN;
        end else begin
          sx = xi << lvl;
          sy = yi << lvl;
          if (!map_to_cell(sx, sy, cell_no)) begin
            res.status = gbcs_pkg::STS_RANGE;
          end else if (grid_lock[cell_no]) begin
            res.status = gbcs_pkg::STS_LOCKED;
          end else if (!(score > grid_score[cell_no])) begin
            res.status = gbcs_pkg::STS_NOT_BETTER;
          end else begin
            grid_x[cell_no] = sx[gbcs_pkg::COORD_W-1:0];
            grid_y[cell_no] = sy[gbcs_pkg::COORD_W-1:0];
            grid_lvl[cell_no] = lvl;
            grid_score[cell_no] = score;
            res.status = gbcs_pkg::STS_STORED;
          end
        end
      end
      gbcs_pkg::OP_READ: begin
        if (int'(idx) >= gbcs_pkg::MAX_CELLS) begin
          res.status = gbcs_pkg::STS_RANGE;
        end else begin
          res.found = grid_score[idx] > sel_min_score;
          res.x = grid_x[idx];
          res.y = grid_y[idx];
          res.level = grid_lvl[idx];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    sel_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result expected none actual status %0d", $time, status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, status);
        check_field("found", want.found, found);
        check_field("out_x", want.x, out_x);
        check_field("out_y", want.y, out_y);
        check_field("out_level", want.level, out_level);
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 32);
  end

  task automatic send_item(input logic [gbcs_pkg::OP_W-1:0] op,
      input logic [gbcs_pkg::COORD_W-1:0] x, input logic [gbcs_pkg::COORD_W-1:0] y,
      input logic [gbcs_pkg::LVL_W-1:0] lvl, input logic [gbcs_pkg::SCORE_W-1:0] score,
      input logic [gbcs_pkg::RD_W-1:0] idx);
    int unsigned gap;
    gap = 0;
    if (!no_idle) while ($urandom_range(99) < 32) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    coord_x <= x;
    coord_y <= y;
    pyramid_level <= lvl;
    corner_score <= score;
    cell_index <= idx;
    do @(posedge clk); while (!in_ready);
    pending_results = {pending_results, predict_item(op, x, y, lvl, score, idx)};
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input gbcs_pkg::cfg_reg_e idx,
                           input logic [gbcs_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      gbcs_pkg::REG_CELL_SIZE:    sel_cell_size = data[gbcs_pkg::CS_W-1:0];
      gbcs_pkg::REG_GRID_WIDTH:   sel_grid_width = data[gbcs_pkg::GW_W-1:0];
      gbcs_pkg::REG_EDGE_MARGIN:  sel_edge_margin = data[gbcs_pkg::MARGIN_W-1:0];
      gbcs_pkg::REG_IMAGE_WIDTH:  sel_image_width = data[gbcs_pkg::COORD_W-1:0];
      gbcs_pkg::REG_IMAGE_HEIGHT: sel_image_height = data[gbcs_pkg::COORD_W-1:0];
      gbcs_pkg::REG_MIN_SCORE:    sel_min_score = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_grid(input int unsigned cs, input int unsigned gw,
      input int unsigned m, input int unsigned iw, input int unsigned ih,
      input logic [gbcs_pkg::SCORE_W-1:0] min_sc);
    settle();
    write_reg(gbcs_pkg::REG_CELL_SIZE, cs);
    write_reg(gbcs_pkg::REG_GRID_WIDTH, gw);
    write_reg(gbcs_pkg::REG_EDGE_MARGIN, m);
    write_reg(gbcs_pkg::REG_IMAGE_WIDTH, iw);
    write_reg(gbcs_pkg::REG_IMAGE_HEIGHT, ih);
    write_reg(gbcs_pkg::REG_MIN_SCORE, min_sc);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_item();
    int unsigned pick, m, top, lvl, x, y, cell_no;
    bit room;
    logic [gbcs_pkg::SCORE_W-1:0] score;
    pick = $urandom_range(99);
    m = sel_edge_margin;
    if (pick < 1) begin
      send_item(gbcs_pkg::OP_CLEAR, 12'($urandom), 12'($urandom), 3'($urandom), $urandom,
                10'($urandom));
    end else if (pick < 16) begin
      send_item((pick < 10) ? gbcs_pkg::OP_LOCK : gbcs_pkg::OP_UNLOCK, 12'(recent_x),
                12'(recent_y), 3'($urandom), $urandom, 10'($urandom));
    end else if (pick < 20) begin
      send_item(($urandom_range(1) == 0) ? gbcs_pkg::OP_LOCK : gbcs_pkg::OP_UNLOCK,
                12'($urandom), 12'($urandom), 3'($urandom), $urandom, 10'($urandom));
    end else if (pick < 60) begin
      room = 1'b0;
      top = 0;
      for (int l = 0; l < 8; l++) begin
        if ((sel_image_width >> l) > 2 * m && (sel_image_height >> l) > 2 * m) begin
          room = 1'b1;
          top = l;
        end
      end
      lvl = $urandom_range(top, 0);
      if (room) begin
        x = $urandom_range(m, (sel_image_width >> lvl) - m - 1);
        y = $urandom_range(m, (sel_image_height >> lvl) - m - 1);
      end else begin
        x = $urandom_range(4095);
        y = $urandom_range(4095);
      end
      case ($urandom_range(3))
        0: score = $urandom;
        1: score = sel_min_score + $urandom_range(15);
        2: score = last_score + $urandom_range(3);
        default: score = $urandom_range(65535);
      endcase
      if (map_to_cell(x << lvl, y << lvl, cell_no)) begin
        recent_cell = cell_no;
        recent_x = x << lvl;
        recent_y = y << lvl;
      end
      last_x = x;
      last_y = y;
      last_lvl = lvl;
      last_score = score;
      send_item(gbcs_pkg::OP_OFFER, 12'(x), 12'(y), 3'(lvl), score, 10'($urandom));
    end else if (pick < 63) begin
      send_item(gbcs_pkg::OP_OFFER, last_x, last_y, last_lvl, last_score, 10'($urandom));
    end else if (pick < 68) begin
      send_item(gbcs_pkg::OP_OFFER, 12'($urandom), 12'($urandom), 3'($urandom), $urandom,
                10'($urandom));
    end else if (pick < 88) begin
      send_item(gbcs_pkg::OP_READ, 12'($urandom), 12'($urandom), 3'($urandom), $urandom,
                10'(recent_cell));
    end else if (pick < 95) begin
      send_item(gbcs_pkg::OP_READ, 12'($urandom), 12'($urandom), 3'($urandom), $urandom,
                10'($urandom));
    end else begin
      send_item(3'($urandom_range(5, 7)), 12'($urandom), 12'($urandom), 3'($urandom),
                $urandom, 10'($urandom));
    end
  endtask

  task automatic test_directed_defaults();
    send_item(gbcs_pkg::OP_READ, 0, 0, 0, 0, 0);
    send_item(gbcs_pkg::OP_READ, 12'hFFF, 12'hFFF, 3'd7, '1, 10'h3FF);
    send_item(gbcs_pkg::OP_OFFER, 100, 50, 0, 32'h0001_0000, 0);
    send_item(gbcs_pkg::OP_OFFER, 100, 50, 0, 32'h0001_0000, 0);
    send_item(gbcs_pkg::OP_OFFER, 101, 51, 0, 32'h0002_0000, 0);
    send_item(gbcs_pkg::OP_READ, 0, 0, 0, 0, 23);
    send_item(gbcs_pkg::OP_LOCK, 100, 50, 0, 0, 0);
    send_item(gbcs_pkg::OP_OFFER, 102, 52, 0, '1, 0);
    send_item(gbcs_pkg::OP_UNLOCK, 110, 40, 0, 0, 0);
    send_item(gbcs_pkg::OP_OFFER, 102, 52, 0, '1, 0);
    send_item(gbcs_pkg::OP_LOCK, 0, 0, 0, 0, 0);
    send_item(gbcs_pkg::OP_UNLOCK, 0, 0, 0, 0, 0);
    send_item(gbcs_pkg::OP_OFFER, 4, 100, 0, '1, 0);
    send_item(gbcs_pkg::OP_OFFER, 100, 4, 0, '1, 0);
    send_item(gbcs_pkg::OP_OFFER, 635, 100, 0, '1, 0);
    send_item(gbcs_pkg::OP_OFFER, 100, 475, 0, '1, 0);
    send_item(gbcs_pkg::OP_OFFER, 5, 5, 7, '1, 0);
    send_item(gbcs_pkg::OP_OFFER, 74, 54, 3, 1, 0);
    send_item(gbcs_pkg::OP_OFFER, 10, 10, 0, 0, 0);
    send_item(gbcs_pkg::OP_LOCK, 12'hFFF, 12'hFFF, 0, 0, 0);
    send_item(gbcs_pkg::OP_UNLOCK, 0, 12'hFFF, 0, 0, 0);
    send_item(3'd5, 12'hFFF, 12'hFFF, 3'd7, '1, 10'h3FF);
    send_item(3'd6, 12'hFFF, 12'hFFF, 3'd7, '1, 10'h3FF);
    send_item(3'd7, 12'hFFF, 12'hFFF, 3'd7, '1, 10'h3FF);
    send_item(gbcs_pkg::OP_READ, 0, 0, 0, 0, 278);
    send_item(gbcs_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
    send_item(gbcs_pkg::OP_READ, 0, 0, 0, 0, 23);
  endtask

  task automatic test_fine_grid_extremes();
    apply_grid(1, 1024, 0, 4095, 4095, 0);
    send_item(gbcs_pkg::OP_OFFER, 0, 0, 0, 1, 0);
    send_item(gbcs_pkg::OP_OFFER, 1023, 0, 0, 1, 0);
    send_item(gbcs_pkg::OP_OFFER, 1024, 0, 0, 1, 0);
    send_item(gbcs_pkg::OP_OFFER, 0, 1, 0, 1, 0);
    send_item(gbcs_pkg::OP_OFFER, 4094, 4094, 0, 1, 0);
    send_item(gbcs_pkg::OP_OFFER, 0, 0, 7, 2, 0);
    send_item(gbcs_pkg::OP_READ, 0, 0, 0, 0, 0);
    repeat (60) send_random_item();
  endtask

  task automatic test_coarse_grid_extremes();
    apply_grid(256, 1, 64, 1, 1, 32'hFFFF_FFFF);
    send_item(gbcs_pkg::OP_READ, 0, 0, 0, 0, 0);
    send_item(gbcs_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
    send_item(gbcs_pkg::OP_OFFER, 64, 64, 0, '1, 0);
    send_item(gbcs_pkg::OP_READ, 0, 0, 0, 0, 0);
    send_item(gbcs_pkg::OP_LOCK, 255, 255, 0, 0, 0);
    send_item(gbcs_pkg::OP_LOCK, 256, 0, 0, 0, 0);
    send_item(gbcs_pkg::OP_UNLOCK, 0, 1023, 0, 0, 0);
    send_item(gbcs_pkg::OP_UNLOCK, 0, 12'hFFF, 0, 0, 0);
    repeat (20) send_random_item();
  endtask

  task automatic test_zero_cell_size();
    apply_grid(0, 64, 2, 64, 16, 0);
    send_item(gbcs_pkg::OP_OFFER, 2, 2, 0, 5, 0);
    send_item(gbcs_pkg::OP_READ, 0, 0, 0, 0, 130);
    repeat (100) send_random_item();
  endtask

  task automatic test_random_grids();
    int unsigned cs, gw, m, iw, ih;
    logic [gbcs_pkg::SCORE_W-1:0] min_sc;
    for (int p = 0; p < 6; p++) begin
      iw = ($urandom_range(3) == 0) ? $urandom_range(1, 4095) : $urandom_range(64, 1024);
      ih = ($urandom_range(3) == 0) ? $urandom_range(1, 4095) : $urandom_range(64, 1024);
      case ($urandom_range(2))
        0: cs = $urandom_range(1, 16);
        1: cs = $urandom_range(17, 64);
        default: cs = $urandom_range(65, 256);
      endcase
      gw = (iw + cs - 1) / cs;
      if (gw > 1024 || $urandom_range(3) == 0) gw = $urandom_range(1, 1024);
      m = ($urandom_range(3) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 8);
      case ($urandom_range(2))
        0: min_sc = '0;
        1: min_sc = $urandom_range(65535);
        default: min_sc = $urandom;
      endcase
      apply_grid(cs, gw, m, iw, ih, min_sc);
      no_idle = (p == 2);
      send_item(gbcs_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
      repeat (170) send_random_item();
      no_idle = 1'b0;
    end
  endtask

  initial begin
    sel_cell_size = gbcs_pkg::CELL_SIZE_RST;
    sel_grid_width = gbcs_pkg::GRID_WIDTH_RST;
    sel_edge_margin = gbcs_pkg::EDGE_MARGIN_RST;
    sel_image_width = gbcs_pkg::IMAGE_WIDTH_RST;
    sel_image_height = gbcs_pkg::IMAGE_HEIGHT_RST;
    sel_min_score = gbcs_pkg::MIN_SCORE_RST;
    wipe_grid();
    recent_x = 0;
    recent_y = 0;
    recent_cell = 0;
    last_x = '0;
    last_y = '0;
    last_lvl = '0;
    last_score = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_defaults();
    test_fine_grid_extremes();
    test_coarse_grid_extremes();
    test_zero_cell_size();
    test_random_grids();
    settle();
    if (mismatch_count == 0) $display("grid_best_corner_selector_unit: match");
    else $display("grid_best_corner_selector_unit: mismatch");
    $finish;
  end

endmodule
